// ----- rtl/core/lmfs_pkg.sv -----
// Shared types and constants for the LED matrix frame shifter.
// No dependencies; used by lmfs_serializer and led_matrix_frame_shifter_top in rtl/core.
package lmfs_pkg;

  // Default geometry and color depth
  localparam int ROWS_DEF       = 8;
  localparam int COLUMNS_DEF    = 8;
  localparam int COLOR_BITS_DEF = 8;

  // Fixed field widths of the channels
  localparam int KIND_W   = 2;
  localparam int POS_W    = 3;
  localparam int INTENS_W = 8;
  localparam int ROWEN_W  = 8;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHIFT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LATCH = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [INTENS_W-1:0] red;
    logic [INTENS_W-1:0] green;
    logic [INTENS_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic               serial_data;
    logic               latch_pulse;
    logic [ROWEN_W-1:0] row_enable;
    logic               last;
  } out_item_t;

  // Sequencer -> serializer
  typedef struct packed {
    logic load;
    logic advance;
  } ser_ctrl_t;

  // Serializer -> sequencer
  typedef struct packed {
    logic data_bit;
    logic last_bit;
  } ser_stat_t;

endpackage

// ----- rtl/core/lmfs_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module lmfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lmfs_serializer.sv -----
// Shared shift unit: loads one pixel word and emits it MSB first, one bit per advance.
// Depends on lmfs_pkg.
module lmfs_serializer #(
  parameter int WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lmfs_pkg::ser_ctrl_t   ctrl,
  input  logic [WIDTH-1:0]      word,
  output lmfs_pkg::ser_stat_t   stat
);
  import lmfs_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] shift_r, shift_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    if (ctrl.load) begin
      shift_nxt = word;
      cnt_nxt   = CW'(WIDTH - 1);
    end else if (ctrl.advance) begin
      shift_nxt = shift_r << 1;
      cnt_nxt   = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.data_bit = shift_r[WIDTH-1];
  assign stat.last_bit = (cnt_r == '0);

endmodule

// ----- rtl/core/led_matrix_frame_shifter_top.sv -----
// LED matrix frame shifter: pixel store plus serial row-scan driver.
// Write request: stored on accept when inside the grid, no result. Shift request:
// S_READ loads the word into the shared serializer, then 3*COLOR_BITS bits follow
// at one per cycle while out_ready is high; next request taken after the last bit.
// Latch request: one result the cycle after accept, held until out_ready.
// Reset (rst_n low, synchronous) clears pixel valid bits (store reads as zero) and rows.
module led_matrix_frame_shifter_top #(
  parameter int ROWS       = lmfs_pkg::ROWS_DEF,
  parameter int COLUMNS    = lmfs_pkg::COLUMNS_DEF,
  parameter int COLOR_BITS = lmfs_pkg::COLOR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lmfs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lmfs_pkg::out_item_t out_item
);
  import lmfs_pkg::*;

  localparam int NPIX   = ROWS * COLUMNS;
  localparam int WORD_W = 3 * COLOR_BITS;
  localparam int AW     = (NPIX > 1) ? $clog2(NPIX) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_LATCH = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [NPIX-1:0]    pix_vld_r, pix_vld_nxt;
  logic [ROWEN_W-1:0] row_r, row_nxt;
  logic               hit_r, hit_nxt;

  logic               in_acc, out_acc, in_grid;
  logic [AW-1:0]      addr;
  logic               ram_we, ram_re;
  logic [WORD_W-1:0]  wdata, rdata;
  ser_ctrl_t          ser_ctrl;
  ser_stat_t          ser_stat;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  assign in_grid = (32'(in_item.x) < COLUMNS) && (32'(in_item.y) < ROWS);
  assign addr    = AW'(32'(in_item.x) * ROWS + 32'(in_item.y));

  // blue in the top bits so it leaves first
  assign wdata = {COLOR_BITS'(in_item.blue), COLOR_BITS'(in_item.green),
                  COLOR_BITS'(in_item.red)};

  assign ram_we = in_acc && (in_item.kind == KIND_WRITE) && in_grid;
  assign ram_re = in_acc && (in_item.kind == KIND_SHIFT) && in_grid;

  lmfs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NPIX)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  assign ser_ctrl.load    = (state_r == S_READ);
  assign ser_ctrl.advance = (state_r == S_SHIFT) && out_acc;

  lmfs_serializer #(
    .WIDTH(WORD_W)
  ) u_ser (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (ser_ctrl),
    .word (hit_r ? rdata : '0),
    .stat (ser_stat)
  );

  always_comb begin
    state_nxt   = state_r;
    pix_vld_nxt = pix_vld_r;
    row_nxt     = row_r;
    hit_nxt     = hit_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_item.kind)
            KIND_WRITE: begin
              if (in_grid) begin
                pix_vld_nxt[addr] = 1'b1;
              end
            end
            KIND_SHIFT: begin
              // pixels never written, or off the store, shift out as zeros
              hit_nxt   = in_grid && pix_vld_r[addr];
              state_nxt = S_READ;
            end
            KIND_LATCH: begin
              if (32'(in_item.x) < COLUMNS) begin
                row_nxt = ROWEN_W'(1) << in_item.x;
              end else begin
                row_nxt = '0;
              end
              state_nxt = S_LATCH;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (out_acc && ser_stat.last_bit) begin
          state_nxt = S_IDLE;
        end
      end
      S_LATCH: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pix_vld_r <= '0;
      row_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      pix_vld_r <= pix_vld_nxt;
      row_r     <= row_nxt;
    end
  end

  assign out_valid            = (state_r == S_SHIFT) || (state_r == S_LATCH);
  assign out_item.serial_data = (state_r == S_SHIFT) && ser_stat.data_bit;
  assign out_item.latch_pulse = (state_r == S_LATCH);
  assign out_item.row_enable  = row_r;
  assign out_item.last        = (state_r == S_LATCH) || ser_stat.last_bit;

endmodule
